>>> design/gld_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the GIF LZW decoder.
// No dependencies; imported by gld_front, gld_core and the top level.
package gld_pkg;

   localparam int TABLE_DEPTH   = 4096;
   localparam int MAX_CODE_BITS = 12;
   localparam int TBL_AW        = $clog2(TABLE_DEPTH);
   localparam int CNT_W         = TBL_AW + 1;
   localparam int NUM_CSR       = 5;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 16;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_CODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ILACE    = 3'd4;

   typedef enum logic [2:0] {
      ST_PIXEL = 3'd0,
      ST_NEED  = 3'd1,
      ST_CLEAR = 3'd2,
      ST_ENDED = 3'd3,
      ST_ERROR = 3'd4,
      ST_TAKEN = 3'd5,
      ST_FULL  = 3'd6
   } status_type;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_PULL = 1'b1
   } op_type;

   // One classified command handed from the front to the back.
   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } cmd_type;

endpackage

>>> design/gld_front.sv
`timescale 1ns / 1ps
// Front end: classifies incoming stream items and queues them (2 entries).
// Depends on gld_pkg.
module gld_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [15:0]      in_data,
   output logic             cmd_valid,
   output gld_pkg::cmd_type cmd,
   input  logic             cmd_pop
);
   import gld_pkg::*;

   cmd_type    q_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   cmd_type    item;

   always_comb begin
      item.op   = in_data[0] ? OP_PULL : OP_PUSH;
      item.data = in_data[8:1];
   end

   assign in_ready  = (cnt_ff != 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rptr_ff];
   assign push      = in_valid && in_ready;

   always_comb begin
      wptr_in = wptr_ff + 1'(push);
      rptr_in = rptr_ff + 1'(cmd_pop);
      cnt_in  = cnt_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= item;
      end
   end

endmodule

>>> design/gld_core.sv
`timescale 1ns / 1ps
// Back end: bit buffer, code expansion through the string table, pixel stack,
// raster addressing and the result register. Depends on gld_pkg.
module gld_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   input  gld_pkg::cmd_type                cmd,
   output logic                            cmd_pop,
   input  logic                            csr_we,
   input  logic [gld_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gld_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic                            out_valid,
   input  logic                            out_ready,
   output gld_pkg::status_type             out_status,
   output logic [7:0]                      out_pixel,
   output logic [31:0]                     out_address,
   output logic                            out_last
);
   import gld_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_WALK = 4'b0010,
      S_POP  = 4'b0100,
      S_EMIT = 4'b1000
   } state_type;

   function automatic logic [3:0] root_bits(input logic [3:0] m);
      if (m < 4'd2) return 4'd2;
      if (m > 4'd8) return 4'd8;
      return m;
   endfunction

   function automatic logic [15:0] next_row(input logic [15:0] r, input logic [15:0] h,
                                            input logic il);
      logic [16:0] rr;
      logic [1:0]  p;
      logic        stop;
      if (!il) return r + 16'd1;
      if (r[2:0] == 3'd0)      p = 2'd0;
      else if (r[2:0] == 3'd4) p = 2'd1;
      else if (r[1:0] == 2'd2) p = 2'd2;
      else                     p = 2'd3;
      case (p)
         2'd0, 2'd1: rr = {1'b0, r} + 17'd8;
         2'd2:       rr = {1'b0, r} + 17'd4;
         default:    rr = {1'b0, r} + 17'd2;
      endcase
      stop = 1'b0;
      for (int k = 0; k < 4; k++) begin
         if (!stop && rr >= {1'b0, h}) begin
            if (p == 2'd3) begin
               rr   = 17'd0;
               stop = 1'b1;
            end else begin
               p = p + 2'd1;
               case (p)
                  2'd1:    rr = 17'd4;
                  2'd2:    rr = 17'd2;
                  default: rr = 17'd1;
               endcase
            end
         end
      end
      return rr[15:0];
   endfunction

   // configuration
   logic [3:0]  mcs_ff, mcs_in;
   logic [15:0] width_ff, width_in, height_ff, height_in, pitch_ff, pitch_in;
   logic        ilace_ff, ilace_in;
   logic [31:0] total_ff;

   // decoder state
   state_type          state_ff, state_in;
   logic [23:0]        bbuf_ff, bbuf_in;
   logic [4:0]         bcnt_ff, bcnt_in;
   logic [3:0]         cw_ff, cw_in;
   logic [CNT_W-1:0]   nfe_ff, nfe_in;
   logic [MAX_CODE_BITS-1:0] prev_ff, prev_in, c_ff, c_in, code_ff, code_in;
   logic [7:0]         pfc_ff, pfc_in;
   logic [15:0]        row_ff, row_in, col_ff, col_in;
   logic [31:0]        done_ff, done_in, prod_ff, prod_in;
   logic               fin_ff, fin_in, err_ff, err_in;
   logic [CNT_W-1:0]   scnt_ff, scnt_in;

   // result register
   logic               ov_ff, ov_in, olast_ff, olast_in;
   status_type         ost_ff, ost_in;
   logic [7:0]         opix_ff, opix_in;
   logic [31:0]        oaddr_ff, oaddr_in;

   // memories
   logic [MAX_CODE_BITS-1:0] pre_mem [TABLE_DEPTH];
   logic [7:0]               suf_mem [TABLE_DEPTH];
   logic [7:0]               stk_mem [TABLE_DEPTH];
   logic [MAX_CODE_BITS-1:0] pre_q;
   logic [7:0]               suf_q, stk_q;
   logic                     tbl_we, stk_we;
   logic [TBL_AW-1:0]        tbl_ra, stk_wa, stk_ra;
   logic [7:0]               stk_wd;

   logic [3:0]               root, new_root;
   logic [MAX_CODE_BITS-1:0] clear_code, first_code, code;
   logic                     out_free;
   logic [CNT_W-1:0]         nfe_next;
   logic [31:0]              done_next;
   logic [15:0]              col_next;

   assign root       = root_bits(mcs_ff);
   assign clear_code = MAX_CODE_BITS'(1) << root;
   assign first_code = clear_code + MAX_CODE_BITS'(2);
   assign out_free   = !ov_ff || out_ready;
   assign code       = bbuf_ff[MAX_CODE_BITS-1:0]
                       & MAX_CODE_BITS'((13'd1 << cw_ff) - 13'd1);
   assign nfe_next   = nfe_ff + CNT_W'(1);
   assign done_next  = done_ff + 32'd1;
   assign col_next   = col_ff + 16'd1;

   always_comb begin
      mcs_in = mcs_ff; width_in = width_ff; height_in = height_ff;
      pitch_in = pitch_ff; ilace_in = ilace_ff;
      state_in = state_ff; bbuf_in = bbuf_ff; bcnt_in = bcnt_ff; cw_in = cw_ff;
      nfe_in = nfe_ff; prev_in = prev_ff; c_in = c_ff; code_in = code_ff;
      pfc_in = pfc_ff; row_in = row_ff; col_in = col_ff; done_in = done_ff;
      prod_in = prod_ff; fin_in = fin_ff; err_in = err_ff; scnt_in = scnt_ff;
      ov_in = ov_ff && !out_ready;
      ost_in = ost_ff; opix_in = opix_ff; oaddr_in = oaddr_ff; olast_in = olast_ff;
      tbl_we = 1'b0; stk_we = 1'b0; stk_wa = scnt_ff[TBL_AW-1:0]; stk_wd = c_ff[7:0];
      tbl_ra = c_ff; stk_ra = TBL_AW'(scnt_ff - CNT_W'(1));
      cmd_pop = 1'b0; new_root = root;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop  = 1'b1;
               ov_in    = 1'b1;
               opix_in  = 8'd0;
               oaddr_in = 32'd0;
               olast_in = 1'b0;
               if (cmd.op == OP_PUSH) begin
                  if (bcnt_ff > 5'd16) begin
                     ost_in = ST_FULL;
                  end else begin
                     bbuf_in = bbuf_ff | (24'(cmd.data) << bcnt_ff);
                     bcnt_in = bcnt_ff + 5'd8;
                     ost_in  = ST_TAKEN;
                  end
               end else if (err_ff) begin
                  ost_in = ST_ERROR;
               end else if (fin_ff) begin
                  ost_in = ST_ENDED;
               end else if (total_ff == 32'd0) begin
                  fin_in = 1'b1;
                  ost_in = ST_ENDED;
               end else if (scnt_ff != '0) begin
                  ov_in    = 1'b0;
                  state_in = S_POP;
               end else if (bcnt_ff < 5'(cw_ff)) begin
                  ost_in = ST_NEED;
               end else begin
                  // consume one code from the bit buffer
                  bbuf_in = bbuf_ff >> cw_ff;
                  bcnt_in = bcnt_ff - 5'(cw_ff);
                  if (code == clear_code + MAX_CODE_BITS'(1)) begin
                     fin_in = 1'b1;
                     ost_in = ST_ENDED;
                  end else if (code == clear_code) begin
                     cw_in   = root + 4'd1;
                     nfe_in  = CNT_W'(first_code);
                     prev_in = clear_code;
                     ost_in  = ST_CLEAR;
                  end else if (CNT_W'(code) < nfe_ff) begin
                     ov_in    = 1'b0;
                     c_in     = code;
                     code_in  = code;
                     tbl_ra   = code;
                     state_in = S_WALK;
                  end else if (CNT_W'(code) != nfe_ff || prev_ff == clear_code
                               || nfe_ff >= CNT_W'(TABLE_DEPTH)) begin
                     err_in = 1'b1;
                     ost_in = ST_ERROR;
                  end else begin
                     // string not yet in the table: previous string plus its first symbol
                     ov_in    = 1'b0;
                     stk_we   = 1'b1;
                     stk_wa   = '0;
                     stk_wd   = pfc_ff;
                     scnt_in  = CNT_W'(1);
                     c_in     = prev_ff;
                     code_in  = code;
                     tbl_ra   = prev_ff;
                     state_in = S_WALK;
                  end
               end
            end
         end
         S_WALK: begin
            if (c_ff >= first_code) begin
               if (scnt_ff >= CNT_W'(TABLE_DEPTH)) begin
                  err_in = 1'b1; scnt_in = '0; state_in = S_IDLE;
                  ov_in = 1'b1; ost_in = ST_ERROR;
               end else begin
                  stk_we  = 1'b1;
                  stk_wd  = suf_q;
                  scnt_in = scnt_ff + CNT_W'(1);
                  c_in    = pre_q;
                  tbl_ra  = pre_q;
               end
            end else if (scnt_ff >= CNT_W'(TABLE_DEPTH) || c_ff >= clear_code) begin
               err_in = 1'b1; scnt_in = '0; state_in = S_IDLE;
               ov_in = 1'b1; ost_in = ST_ERROR;
            end else begin
               stk_we  = 1'b1;
               scnt_in = scnt_ff + CNT_W'(1);
               if (prev_ff != clear_code && nfe_ff < CNT_W'(TABLE_DEPTH)) begin
                  tbl_we = 1'b1;
                  nfe_in = nfe_next;
                  if (nfe_next >= (CNT_W'(1) << cw_ff) && cw_ff < 4'(MAX_CODE_BITS)) begin
                     cw_in = cw_ff + 4'd1;
                  end
               end
               prev_in  = code_ff;
               pfc_in   = c_ff[7:0];
               state_in = S_POP;
            end
         end
         S_POP: begin
            scnt_in  = scnt_ff - CNT_W'(1);
            prod_in  = row_ff * pitch_ff;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            ov_in    = 1'b1;
            ost_in   = ST_PIXEL;
            opix_in  = stk_q;
            oaddr_in = prod_ff + 32'(col_ff);
            done_in  = done_next;
            olast_in = (done_next >= total_ff);
            if (col_next >= width_ff) begin
               col_in = 16'd0;
               row_in = next_row(row_ff, height_ff, ilace_ff);
            end else begin
               col_in = col_next;
            end
            if (done_next >= total_ff) begin
               fin_in  = 1'b1;
               scnt_in = '0;
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      // register write to a valid index: store the field and restart decoding
      if (csr_we && csr_index < CSR_IDX_W'(NUM_CSR)) begin
         unique case (csr_index)
            CSR_MIN_CODE: mcs_in    = csr_wdata[3:0];
            CSR_WIDTH:    width_in  = csr_wdata;
            CSR_HEIGHT:   height_in = csr_wdata;
            CSR_PITCH:    pitch_in  = csr_wdata;
            CSR_ILACE:    ilace_in  = csr_wdata[0];
            default:      ;
         endcase
         new_root = root_bits(mcs_in);
         state_in = S_IDLE; scnt_in = '0; bbuf_in = '0; bcnt_in = '0;
         cw_in    = new_root + 4'd1;
         nfe_in   = (CNT_W'(1) << new_root) + CNT_W'(2);
         prev_in  = MAX_CODE_BITS'(1) << new_root;
         pfc_in = '0; row_in = '0; col_in = '0; done_in = '0;
         fin_in = 1'b0; err_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mcs_ff <= 4'd8; width_ff <= 16'd1; height_ff <= 16'd1;
         pitch_ff <= 16'd1; ilace_ff <= 1'b0;
         state_ff <= S_IDLE; scnt_ff <= '0; bbuf_ff <= '0; bcnt_ff <= '0;
         cw_ff <= 4'd9; nfe_ff <= CNT_W'(258); prev_ff <= MAX_CODE_BITS'(256);
         pfc_ff <= '0; row_ff <= '0; col_ff <= '0; done_ff <= '0;
         fin_ff <= 1'b0; err_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         mcs_ff <= mcs_in; width_ff <= width_in; height_ff <= height_in;
         pitch_ff <= pitch_in; ilace_ff <= ilace_in;
         state_ff <= state_in; scnt_ff <= scnt_in; bbuf_ff <= bbuf_in; bcnt_ff <= bcnt_in;
         cw_ff <= cw_in; nfe_ff <= nfe_in; prev_ff <= prev_in;
         pfc_ff <= pfc_in; row_ff <= row_in; col_ff <= col_in; done_ff <= done_in;
         fin_ff <= fin_in; err_ff <= err_in; ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      c_ff     <= c_in;
      code_ff  <= code_in;
      prod_ff  <= prod_in;
      total_ff <= width_ff * height_ff;
      ost_ff   <= ost_in;
      opix_ff  <= opix_in;
      oaddr_ff <= oaddr_in;
      olast_ff <= olast_in;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         pre_mem[nfe_ff[TBL_AW-1:0]] <= prev_ff;
         suf_mem[nfe_ff[TBL_AW-1:0]] <= c_ff[7:0];
      end
      pre_q <= pre_mem[tbl_ra];
      suf_q <= suf_mem[tbl_ra];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_wa] <= stk_wd;
      end
      stk_q <= stk_mem[stk_ra];
   end

   assign out_valid   = ov_ff;
   assign out_status  = ost_ff;
   assign out_pixel   = opix_ff;
   assign out_address = oaddr_ff;
   assign out_last    = olast_ff;

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      scnt_ff <= CNT_W'(TABLE_DEPTH))
      else $error("pixel stack count past depth");
   a_bits_bound: assert property (@(posedge clock) disable iff (reset)
      bcnt_ff <= 5'd24)
      else $error("bit count past buffer size");
   a_width_bound: assert property (@(posedge clock) disable iff (reset)
      cw_ff >= 4'd3 && cw_ff <= 4'(MAX_CODE_BITS))
      else $error("code width out of range");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> !ov_ff || out_ready)
      else $error("pixel would overwrite a pending result");
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      err_ff && !csr_we |=> err_ff)
      else $error("error flag dropped without restart");

endmodule

>>> design/gif_lzw_decoder_top.sv
`timescale 1ns / 1ps
// Push: queued in the front, then registered as the result; one per cycle sustained
// while results are taken. A status-only pull (need data, clear, end, most errors)
// skips the walk, pop and emit states. A pixel pull passes pop (stack read, row*pitch
// multiply) and emit, after a prefix-chain walk for a new code, before the next is taken.
// Reset is synchronous, active high; it restores register defaults (root size 8,
// 1x1 image) and the decoder state; string table contents are left as they are.
module gif_lzw_decoder_top (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] operation
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] pixel_value, [39:8] pixel_address
   output logic [2:0]  rsp_tuser,   // [2:0] status
   output logic        rsp_tlast,   // last_pixel
   // configuration
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import gld_pkg::*;

   cmd_type    cmd;
   logic       cmd_valid, cmd_pop;
   status_type status;
   logic [7:0] pixel;
   logic [31:0] address;

   // Classify and queue each transfer; the queue decouples input from decoding.
   gld_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   ({7'd0, req_tdata, req_tuser}),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // Decode, expand codes, pop pixels and hold the result until taken.
   gld_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_status  (status),
      .out_pixel   (pixel),
      .out_address (address),
      .out_last    (rsp_tlast)
   );

   // Pack result fields, lowest field first; the status travels as tuser.
   assign rsp_tdata = {address, pixel};
   assign rsp_tuser = status;

endmodule

>>> verif/gif_lzw_decoder_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the GIF LZW decoder top level: encodes random images
// into LZW streams, drives push/pull transfers and checks every result transfer.
// Depends on gld_pkg (types, register indexes) and gif_lzw_decoder_top.
module gif_lzw_decoder_top_tb;
   import gld_pkg::*;

   // One result item as the decoder reports it.
   typedef struct {
      status_type  status;
      logic [7:0]  pixel;
      logic [31:0] addr;
      logic        last;
   } pixel_result_type;

   // One row of the directed stimulus table.
   typedef struct {
      op_type     op;
      logic [7:0] data;
      bit         typed;    // expected status read off by hand
      status_type status;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   gif_lzw_decoder_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   localparam int unsigned CYCLE_LIMIT = 6000000;

   // Expected results in transfer order.
   pixel_result_type pending_pixels [$];

   function automatic void queue_expected(input pixel_result_type r);
      pending_pixels = {pending_pixels, r};
   endfunction

   // ------------------------------------------------------------------
   // Clock, cycle limit
   // ------------------------------------------------------------------
   initial clock = 1'b0;
   always #10 clock = ~clock;

   int unsigned cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_pixels.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Decoder predictor: configuration copy and decoding state
   // ------------------------------------------------------------------
   logic [3:0]  cfg_root_raw;
   logic [15:0] cfg_width, cfg_height, cfg_pitch;
   logic        cfg_ilace;

   logic [11:0] lzw_prefix [TABLE_DEPTH];
   logic [7:0]  lzw_suffix [TABLE_DEPTH];
   logic [7:0]  sym_stack  [TABLE_DEPTH];
   int unsigned stk_n, bitbuf, nbits, cw, next_ent, prev_code, prev_first;
   int unsigned cur_row, cur_col, px_done;
   bit          dec_finished, dec_failed;

   function automatic int unsigned root_bits();
      if (cfg_root_raw < 2) return 2;
      if (cfg_root_raw > 8) return 8;
      return cfg_root_raw;
   endfunction

   function automatic void restart_decoder();
      int unsigned rb;
      rb = root_bits();
      stk_n = 0; bitbuf = 0; nbits = 0;
      cw = rb + 1;
      next_ent = (1 << rb) + 2;
      prev_code = 1 << rb;
      prev_first = 0;
      cur_row = 0; cur_col = 0; px_done = 0;
      dec_finished = 0; dec_failed = 0;
   endfunction

   function automatic void step_row();
      int unsigned r, pass;
      r = cur_row;
      if (!cfg_ilace) begin
         cur_row = (r + 1) & 16'hFFFF;
         return;
      end
      if ((r & 7) == 0) pass = 0;
      else if ((r & 7) == 4) pass = 1;
      else if ((r & 3) == 2) pass = 2;
      else pass = 3;
      r += (pass < 2) ? 8 : (pass == 2) ? 4 : 2;
      // skip passes that hold no rows, wrap to row 0 after the last one
      while (r >= cfg_height) begin
         pass++;
         if (pass > 3) begin
            r = 0;
            break;
         end
         r = (pass == 0) ? 0 : (pass == 1) ? 4 : (pass == 2) ? 2 : 1;
      end
      cur_row = r & 16'hFFFF;
   endfunction

   function automatic status_type set_error();
      dec_failed = 1;
      stk_n = 0;
      return ST_ERROR;
   endfunction

   // Read one code and expand it onto the symbol stack.
   function automatic status_type read_code();
      int unsigned rb, clr, first, code, c;
      rb = root_bits();
      clr = 1 << rb;
      first = clr + 2;
      code = bitbuf & ((1 << cw) - 1);
      bitbuf = bitbuf >> cw;
      nbits -= cw;
      if (code == clr + 1) begin
         dec_finished = 1;
         return ST_ENDED;
      end
      if (code == clr) begin
         cw = rb + 1;
         next_ent = first;
         prev_code = clr;
         return ST_CLEAR;
      end
      stk_n = 0;
      if (code < next_ent) begin
         c = code;
      end else begin
         if (code != next_ent || prev_code == clr || next_ent >= TABLE_DEPTH)
            return set_error();
         // string not yet in the table: previous string plus its own first symbol
         sym_stack[0] = prev_first[7:0];
         stk_n = 1;
         c = prev_code;
      end
      while (c >= first && c < TABLE_DEPTH) begin
         if (stk_n >= TABLE_DEPTH) return set_error();
         sym_stack[stk_n] = lzw_suffix[c];
         stk_n++;
         c = lzw_prefix[c];
      end
      if (stk_n >= TABLE_DEPTH || c >= clr) return set_error();
      sym_stack[stk_n] = c[7:0];
      stk_n++;
      if (prev_code != clr && next_ent < TABLE_DEPTH) begin
         lzw_prefix[next_ent] = prev_code[11:0];
         lzw_suffix[next_ent] = c[7:0];
         next_ent++;
         if (next_ent >= (1 << cw) && cw < MAX_CODE_BITS) cw++;
      end
      prev_code = code;
      prev_first = c;
      return ST_PIXEL;
   endfunction

   function automatic pixel_result_type decode_item(op_type op, logic [7:0] data);
      pixel_result_type r;
      logic [31:0]      total, addr;
      status_type       st;
      r = '{ST_PIXEL, 8'd0, 32'd0, 1'b0};
      total = cfg_width * cfg_height;
      if (op == OP_PUSH) begin
         if (nbits > 16) begin
            r.status = ST_FULL;
            return r;
         end
         bitbuf = (bitbuf | (int'(data) << nbits)) & 24'hFFFFFF;
         nbits += 8;
         r.status = ST_TAKEN;
         return r;
      end
      if (dec_failed) begin
         r.status = ST_ERROR;
         return r;
      end
      if (dec_finished) begin
         r.status = ST_ENDED;
         return r;
      end
      if (total == 0) begin
         dec_finished = 1;
         r.status = ST_ENDED;
         return r;
      end
      if (stk_n == 0) begin
         if (nbits < cw) begin
            r.status = ST_NEED;
            return r;
         end
         st = read_code();
         if (st != ST_PIXEL) begin
            r.status = st;
            return r;
         end
      end
      stk_n--;
      r.pixel = sym_stack[stk_n];
      addr = cur_row * cfg_pitch + cur_col;
      r.addr = addr;
      px_done++;
      r.last = (px_done >= total);
      cur_col++;
      if (cur_col >= cfg_width) begin
         cur_col = 0;
         step_row();
      end
      if (r.last) begin
         dec_finished = 1;
         stk_n = 0;
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // LZW encoder for stimulus; tracks the code width the decoder will use
   // ------------------------------------------------------------------
   logic [7:0]      stream_bytes [$];
   int unsigned     phrase_code [int unsigned];
   longint unsigned enc_acc;
   int unsigned     enc_nacc, enc_w, enc_dec_next, enc_add_next, enc_ncodes;

   function automatic void add_byte(input logic [7:0] b);
      stream_bytes = {stream_bytes, b};
   endfunction

   function automatic void put_code(int unsigned code);
      enc_acc |= longint'(code) << enc_nacc;
      enc_nacc += enc_w;
      while (enc_nacc >= 8) begin
         add_byte(enc_acc[7:0]);
         enc_acc >>= 8;
         enc_nacc -= 8;
      end
   endfunction

   function automatic void restart_phrases(int unsigned rb);
      phrase_code.delete();
      enc_w = rb + 1;
      enc_dec_next = (1 << rb) + 2;
      enc_add_next = enc_dec_next;
      enc_ncodes = 0;
   endfunction

   function automatic void put_data_code(int unsigned code);
      put_code(code);
      // the decoder adds an entry for every data code but the first after a clear, while the table has room
      if (enc_ncodes >= 1 && enc_dec_next < TABLE_DEPTH) begin
         enc_dec_next++;
         if (enc_dec_next >= (1 << enc_w) && enc_w < MAX_CODE_BITS) enc_w++;
      end
      enc_ncodes++;
   endfunction

   function automatic void build_stream(int unsigned rb, int unsigned npix, bit with_end);
      int unsigned cur, c, key, prev_pix;
      stream_bytes.delete();
      enc_acc = 0;
      enc_nacc = 0;
      restart_phrases(rb);
      if (npix == 0) return;
      if ($urandom_range(3) != 0) begin
         put_code(1 << rb);
         restart_phrases(rb);
      end
      cur = $urandom_range((1 << rb) - 1);
      prev_pix = cur;
      for (int unsigned i = 1; i < npix; i++) begin
         // runs of one value make long strings and self-referencing codes
         c = $urandom_range(1) ? prev_pix : $urandom_range((1 << rb) - 1);
         prev_pix = c;
         key = cur * 256 + c;
         if (phrase_code.exists(key)) begin
            cur = phrase_code[key];
         end else begin
            put_data_code(cur);
            if (enc_add_next < TABLE_DEPTH) begin
               phrase_code[key] = enc_add_next;
               enc_add_next++;
            end
            if ($urandom_range(299) == 0) begin
               put_code(1 << rb);
               restart_phrases(rb);
            end
            cur = c;
         end
      end
      put_data_code(cur);
      if (with_end) put_code((1 << rb) + 1);
      if (enc_nacc > 0) add_byte(enc_acc[7:0]);
   endfunction

   // ------------------------------------------------------------------
   // Result side: stall generator and checker
   // ------------------------------------------------------------------
   int unsigned   fail_count = 0;
   int unsigned   recv_stall_pct = 0;
   int unsigned   send_idle_pct = 0;
   int unsigned   hold_cycles = 0;

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   // Drop tready at random; hold it low for a long stretch when asked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Sample at the falling edge: the transfer completes at the next rising edge.
   always @(negedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("unexpected result, status", rsp_tuser, 0);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_tuser !== want.status)
               report_mismatch("status", rsp_tuser, want.status);
            if (rsp_tdata[7:0] !== want.pixel)
               report_mismatch("pixel_value", rsp_tdata[7:0], want.pixel);
            if (rsp_tdata[39:8] !== want.addr)
               report_mismatch("pixel_address", rsp_tdata[39:8], want.addr);
            if (rsp_tlast !== want.last)
               report_mismatch("last_pixel", rsp_tlast, want.last);
         end
      end
   end

   // ------------------------------------------------------------------
   // Input side
   // ------------------------------------------------------------------
   int unsigned items_sent = 0;

   // Predict, queue the expectation, then hold the transfer until accepted.
   task automatic send_item(input op_type op, input logic [7:0] data,
                            output status_type st);
      pixel_result_type r;
      bit               took;
      r = decode_item(op, data);
      st = r.status;
      queue_expected(r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= op;
      do begin
         @(negedge clock);
         took = req_tready;
         @(posedge clock);
      end while (!took);
      items_sent++;
   endtask

   task automatic idle_input();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait until every expected result has arrived, then let the pipe settle.
   task automatic wait_drained();
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_MIN_CODE: cfg_root_raw = val[3:0];
         CSR_WIDTH:    cfg_width    = val;
         CSR_HEIGHT:   cfg_height   = val;
         CSR_PITCH:    cfg_pitch    = val;
         CSR_ILACE:    cfg_ilace    = val[0];
         default: ;
      endcase
      restart_decoder();
   endtask

   // Feed one encoded image; mostly well-formed pushes and pulls, some noise.
   task automatic run_image(input int unsigned npix_cap);
      int unsigned idx, tail, needs, budget, n;
      status_type  st;
      logic [7:0]  d;
      idx = 0; tail = 0; needs = 0; n = 0;
      budget = 8 * npix_cap + 4 * stream_bytes.size() + 40;
      forever begin
         if (dec_finished || dec_failed) begin
            if (tail >= 3) break;
            tail++;
         end
         if (idx >= stream_bytes.size() && needs >= 3) break;
         if (n >= budget) break;
         d = 8'($urandom_range(255));
         if (idx < stream_bytes.size() && nbits <= 16 && $urandom_range(2) != 0) begin
            send_item(OP_PUSH, stream_bytes[idx], st);
            if (st == ST_TAKEN) idx++;
         end else if (idx < stream_bytes.size() && nbits > 16 && $urandom_range(9) == 0) begin
            send_item(OP_PUSH, d, st);           // refused: buffer holds too much
         end else if (idx >= stream_bytes.size() && $urandom_range(19) == 0) begin
            send_item(OP_PUSH, d, st);           // stray byte past the stream
         end else begin
            send_item(OP_PULL, d, st);
            if (st == ST_NEED && idx >= stream_bytes.size()) needs++;
         end
         n++;
      end
   endtask

   // ------------------------------------------------------------------
   // Directed table: reset defaults (root 8, 1x1 image)
   // ------------------------------------------------------------------
   dir_row_type dir_rows [] = '{
      '{OP_PULL, 8'h00, 1'b1, ST_NEED},    // nothing pushed yet
      '{OP_PUSH, 8'h00, 1'b1, ST_TAKEN},
      '{OP_PUSH, 8'h01, 1'b1, ST_TAKEN},   // 9-bit clear code now held
      '{OP_PULL, 8'hFF, 1'b1, ST_CLEAR},
      '{OP_PUSH, 8'hFF, 1'b1, ST_TAKEN},
      '{OP_PUSH, 8'hFF, 1'b1, ST_TAKEN},   // 23 bits held
      '{OP_PUSH, 8'hA5, 1'b1, ST_FULL},
      '{OP_PULL, 8'h00, 1'b1, ST_ERROR},   // code past the table
      '{OP_PULL, 8'h5A, 1'b1, ST_ERROR},   // error is sticky
      '{OP_PUSH, 8'h00, 1'b1, ST_TAKEN},   // pushes still taken
      '{OP_PULL, 8'hFF, 1'b0, ST_ERROR}
   };

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      pixel_result_type r;
      status_type       st;
      int unsigned      img, rb, total, npix;
      logic [15:0]      w, h, p;
      logic [3:0]       root_raw;
      logic             il;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         lzw_prefix[i] = '0;
         lzw_suffix[i] = '0;
         sym_stack[i]  = '0;
      end
      cfg_root_raw = 4'd8;
      cfg_width = 16'd1; cfg_height = 16'd1; cfg_pitch = 16'd1; cfg_ilace = 1'b0;
      restart_decoder();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table; typed rows replace the predicted expectation.
      foreach (dir_rows[i]) begin
         if (dir_rows[i].typed) begin
            r = decode_item(dir_rows[i].op, dir_rows[i].data);
            r = '{dir_rows[i].status, 8'd0, 32'd0, 1'b0};
            queue_expected(r);
            while ($urandom_range(99) < send_idle_pct) idle_input();
            req_tvalid <= 1'b1;
            req_tdata  <= dir_rows[i].data;
            req_tuser  <= dir_rows[i].op;
            begin
               bit took;
               do begin
                  @(negedge clock);
                  took = req_tready;
                  @(posedge clock);
               end while (!took);
            end
            items_sent++;
         end else begin
            send_item(dir_rows[i].op, dir_rows[i].data, st);
         end
      end
      req_tvalid <= 1'b0;

      // Random images, cycling through idling phases.
      img = 0;
      while (items_sent < 1100 || img < 12) begin
         wait_drained();
         case (img % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
         endcase

         root_raw = ($urandom_range(7) == 0) ? 4'($urandom_range(15))
                                             : 4'($urandom_range(8, 2));
         w  = 16'($urandom_range(12, 1));
         h  = 16'($urandom_range(10, 1));
         p  = ($urandom_range(1)) ? w : 16'($urandom_range(65535));
         il = 1'($urandom_range(1));
         if ($urandom_range(9) == 0) w = 16'd0;     // empty image
         if ($urandom_range(9) == 0) h = 16'd0;
         if (img == 0) begin                    // largest settings
            root_raw = 4'd15; w = 16'hFFFF; h = 16'hFFFF; p = 16'hFFFF; il = 1'b1;
         end else if (img == 1) begin           // smallest settings
            root_raw = 4'd0; w = 16'd1; h = 16'd1; p = 16'd0; il = 1'b0;
         end else if (img == 5) begin           // long enough to widen the codes
            root_raw = 4'd2; w = 16'd24; h = 16'd10; p = 16'd32; il = 1'b0;
            send_idle_pct = 0; recv_stall_pct = 0;
         end
         write_csr(CSR_MIN_CODE, {12'd0, root_raw});
         write_csr(CSR_WIDTH, w);
         write_csr(CSR_HEIGHT, h);
         write_csr(CSR_PITCH, p);
         write_csr(CSR_ILACE, {15'd0, il});

         rb = root_bits();
         total = w * h;
         npix = (img == 5) ? total : (total > 80) ? 80 : total;
         build_stream(rb, npix, (npix == total) && ($urandom_range(3) != 0));
         // flip one bit now and then to corrupt the stream
         if (stream_bytes.size() > 0 && $urandom_range(9) == 0)
            stream_bytes[$urandom_range(stream_bytes.size() - 1)] ^= 8'(1 << $urandom_range(7));
         if (img == 2) hold_cycles = 400;       // long stall: let the decoder back up
         run_image(npix);
         req_tvalid <= 1'b0;
         img++;
      end

      wait_drained();
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
